FILE: hw/rtl/bcw_pkg.sv
`timescale 1ns / 1ps

package bcw_pkg;

  localparam int CRC_W     = 24;
  localparam int CHANNEL_W = 6;
  localparam int BYTE_W    = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [CRC_W-1:0]  CRC_TAPS    = 24'h00065B;
  localparam logic [CRC_W-1:0]  CRC_SEED    = 24'h555555;
  localparam logic [BYTE_W-1:0] WHITEN_TAPS = 8'h11;
  localparam logic [BYTE_W-1:0] WHITEN_OR   = 8'h02;
  localparam logic [CHANNEL_W-1:0] CHANNEL_RESET = 6'd37;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_CRC_INIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL  = 1'b1;

  typedef struct packed {
    logic [CRC_W-1:0]     crc_init;
    logic [CHANNEL_W-1:0] channel;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] lfsr;
    logic [BYTE_W-1:0] data;
  } whiten_t;

  function automatic logic [BYTE_W-1:0] rev8(input logic [BYTE_W-1:0] x);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = x[BYTE_W-1-i];
    end
    return r;
  endfunction

  // Eight CRC bit steps, data LSB first
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                input logic [BYTE_W-1:0] d);
    logic [CRC_W-1:0] c;
    logic             top;
    c = c_in;
    for (int i = 0; i < BYTE_W; i++) begin
      top = c[CRC_W-1];
      c   = {c[CRC_W-2:0], 1'b0};
      if (top != d[i]) begin
        c = c ^ CRC_TAPS;
      end
    end
    return c;
  endfunction

  function automatic whiten_t whiten_byte(input logic [BYTE_W-1:0] w_in,
                                          input logic [BYTE_W-1:0] d_in);
    whiten_t r;
    r.lfsr = w_in;
    r.data = d_in;
    for (int i = 0; i < BYTE_W; i++) begin
      if (r.lfsr[BYTE_W-1]) begin
        r.lfsr    = r.lfsr ^ WHITEN_TAPS;
        r.data[i] = ~r.data[i];
      end
      r.lfsr = {r.lfsr[BYTE_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/bcw_if.sv
`timescale 1ns / 1ps

interface bcw_in_if;
  import bcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface bcw_out_if;
  import bcw_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last_out;
  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

interface bcw_cfg_if;
  import bcw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CRC_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/bcw_cfg_regs.sv
`timescale 1ns / 1ps

module bcw_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  bcw_cfg_if.sink       cfg,
  output bcw_pkg::cfg_t regs
);
  import bcw_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.crc_init <= CRC_SEED;
      regs.channel  <= CHANNEL_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_CRC_INIT: regs.crc_init <= cfg.data;
        REG_CHANNEL:  regs.channel  <= cfg.data[CHANNEL_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/bcw_encoder.sv
`timescale 1ns / 1ps

module bcw_encoder (
  input  logic          clk,
  input  logic          rst,
  input  bcw_pkg::cfg_t regs,
  bcw_in_if.sink        din,
  bcw_out_if.source     dout
);
  import bcw_pkg::*;

  // input stage
  logic              in_full;
  logic [BYTE_W-1:0] in_data;
  logic              in_last;

  // packet state
  logic [CRC_W-1:0]  crc_reg;
  logic [BYTE_W-1:0] whiten_reg;
  logic              at_start;
  logic [1:0]        tail_cnt;   // CRC bytes still to send

  // result register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  logic              out_load;
  logic              in_consume;
  logic [CRC_W-1:0]  crc_eff;
  logic [BYTE_W-1:0] whiten_eff;
  logic [BYTE_W-1:0] tail_src;
  whiten_t           wh_data;
  whiten_t           wh_tail;
  logic [CRC_W-1:0]  crc_next;

  assign out_load   = !out_valid || dout.ready;
  assign in_consume = in_full && (tail_cnt == 2'd0) && out_load;
  assign din.ready  = !in_full || in_consume;

  assign crc_eff    = at_start ? regs.crc_init : crc_reg;
  assign whiten_eff = at_start ? (rev8({2'b00, regs.channel}) | WHITEN_OR) : whiten_reg;
  assign crc_next   = crc_byte(crc_eff, in_data);
  assign wh_data    = whiten_byte(whiten_eff, in_data);

  always_comb begin
    case (tail_cnt)
      2'd3:    tail_src = crc_reg[23:16];
      2'd2:    tail_src = crc_reg[15:8];
      default: tail_src = crc_reg[7:0];
    endcase
  end
  assign wh_tail = whiten_byte(whiten_reg, rev8(tail_src));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (din.valid && din.ready) begin
      in_full <= 1'b1;
    end else if (in_consume) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      in_data <= din.data_byte;
      in_last <= din.last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg    <= CRC_SEED;
      whiten_reg <= '0;
      at_start   <= 1'b1;
      tail_cnt   <= 2'd0;
      out_valid  <= 1'b0;
    end else if (out_load) begin
      if (tail_cnt != 2'd0) begin
        whiten_reg <= wh_tail.lfsr;
        tail_cnt   <= tail_cnt - 2'd1;
        out_valid  <= 1'b1;
      end else if (in_full) begin
        crc_reg    <= crc_next;
        whiten_reg <= wh_data.lfsr;
        at_start   <= in_last;
        tail_cnt   <= in_last ? 2'd3 : 2'd0;
        out_valid  <= 1'b1;
      end else begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (tail_cnt != 2'd0) begin
        out_byte <= rev8(wh_tail.data);
        out_last <= (tail_cnt == 2'd1);
      end else begin
        out_byte <= rev8(wh_data.data);
        out_last <= 1'b0;
      end
    end
  end

  assign dout.valid    = out_valid;
  assign dout.out_byte = out_byte;
  assign dout.last_out = out_last;

  a_tail_start: assert property (@(posedge clk) disable iff (rst)
    (in_consume && in_last) |=> (tail_cnt == 2'd3))
    else $error("tail count not loaded after last word");

  a_last_out: assert property (@(posedge clk) disable iff (rst)
    (out_load && tail_cnt == 2'd1) |=> (out_valid && out_last && tail_cnt == 2'd0))
    else $error("final CRC word not flagged");

  a_tail_restart: assert property (@(posedge clk) disable iff (rst)
    (tail_cnt != 2'd0) |-> (at_start && !in_consume))
    else $error("payload consumed during CRC tail");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && !in_consume) |=> (in_full && $stable(in_data) && $stable(in_last)))
    else $error("input stage lost a word");

endmodule

FILE: hw/rtl/ble_packet_crc_whiten_encoder_top.sv
`timescale 1ns / 1ps

// Link-layer packet encoder: CRC-24 and whitening, one payload byte per word.
// data_in carries payload bytes with last_byte on the final one; data_out
// returns one whitened, bit-reversed byte per payload word, and after the
// last payload byte three CRC bytes, the third flagged with last_out.
// cfg writes crc_init (index 0) and channel (index 1) with ready always high;
// both take effect at the next packet start, so write them between packets.
// An accepted word passes through the input register and then the result
// register before it appears on data_out.
// Throughput: one word per cycle while data_out.ready holds high; during the
// three CRC bytes on the output register, no payload word is consumed.
// An input register and the result register hold one word each, so input is
// still taken while a finished result waits; a stalled receiver holds the
// result register and fills the input register, then data_in.ready drops.
// Reset (rst, synchronous): crc_init = 0x555555, channel = 37, both stages
// empty, next word starts a packet.

module ble_packet_crc_whiten_encoder_top (
  input logic       clk,
  input logic       rst,
  bcw_cfg_if.sink   cfg,
  bcw_in_if.sink    data_in,
  bcw_out_if.source data_out
);
  import bcw_pkg::*;

  cfg_t regs;

  bcw_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  bcw_encoder u_enc (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .din  (data_in),
    .dout (data_out)
  );

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import bcw_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int ITEM_TARGET   = 450;
  localparam int CALM_FROM     = 390;

  typedef enum int { OP_WORD, OP_WRITE, OP_SETTLE } op_kind_t;

  typedef struct {
    op_kind_t             kind;
    logic [BYTE_W-1:0]    data;
    logic                 fin;
    logic [CFG_IDX_W-1:0] idx;
    logic [CRC_W-1:0]     wdata;
    bit                   calm;
  } op_t;

  typedef struct packed {
    logic [BYTE_W-1:0] val;
    logic              fin;
  } enc_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  bcw_cfg_if cfg_ch ();
  bcw_in_if  in_ch ();
  bcw_out_if out_ch ();

  ble_packet_crc_whiten_encoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_ch),
    .data_in  (in_ch),
    .data_out (out_ch)
  );

  op_t       ops[$];
  enc_word_t expected_words[$];

  // encoder shadow state
  logic [CRC_W-1:0]     seed_crc  = CRC_SEED;
  logic [CHANNEL_W-1:0] seed_chan = CHANNEL_RESET;
  logic [CRC_W-1:0]     crc_acc   = CRC_SEED;
  logic [BYTE_W-1:0]    wht       = '0;
  logic                 new_pkt   = 1'b1;

  int  errors;
  int  words_sent;
  int  words_seen;
  int  packets_seen;
  int  reg_writes;
  int  planned;
  bit  calm_fill;
  bit  quiet;
  int  in_gap_pct  = 20;
  int  out_stall_pct = 20;
  int  idle_left;
  int  stall_left;
  int  settle_left = SETTLE_CYCLES;

  function automatic logic [BYTE_W-1:0] mirror8(input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] r;
    for (int i = 0; i < BYTE_W; i++) begin
      r[i] = b[BYTE_W-1-i];
    end
    return r;
  endfunction

  // whitening LFSR advances one step per data bit, LSB first
  function automatic logic [BYTE_W-1:0] scramble(input logic [BYTE_W-1:0] d);
    logic [BYTE_W-1:0] r;
    r = d;
    for (int i = 0; i < BYTE_W; i++) begin
      if (wht[BYTE_W-1]) begin
        wht  = wht ^ WHITEN_TAPS;
        r[i] = ~r[i];
      end
      wht = {wht[BYTE_W-2:0], 1'b0};
    end
    return r;
  endfunction

  task automatic encode_word(input logic [BYTE_W-1:0] b, input logic fin);
    logic      top;
    enc_word_t w;
    if (new_pkt) begin
      crc_acc = seed_crc;
      wht     = mirror8({{(BYTE_W-CHANNEL_W){1'b0}}, seed_chan}) | WHITEN_OR;
      new_pkt = 1'b0;
    end
    for (int i = 0; i < BYTE_W; i++) begin
      top     = crc_acc[CRC_W-1];
      crc_acc = {crc_acc[CRC_W-2:0], 1'b0};
      if (top != b[i]) begin
        crc_acc = crc_acc ^ CRC_TAPS;
      end
    end
    w.val = mirror8(scramble(b));
    w.fin = 1'b0;
    expected_words.push_back(w);
    if (fin) begin
      // CRC tail, high byte first
      for (int k = 0; k < 3; k++) begin
        w.val = mirror8(scramble(mirror8(crc_acc[(2-k)*8 +: 8])));
        w.fin = (k == 2);
        expected_words.push_back(w);
      end
      new_pkt = 1'b1;
    end
  endtask

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  task automatic add_word(input logic [BYTE_W-1:0] d, input logic fin);
    op_t op;
    op.kind  = OP_WORD;
    op.data  = d;
    op.fin   = fin;
    op.idx   = '0;
    op.wdata = '0;
    op.calm  = calm_fill;
    ops.push_back(op);
    planned++;
  endtask

  task automatic add_write(input logic [CFG_IDX_W-1:0] idx, input logic [CRC_W-1:0] v);
    op_t op;
    op.kind  = OP_WRITE;
    op.data  = '0;
    op.fin   = 1'b0;
    op.idx   = idx;
    op.wdata = v;
    op.calm  = calm_fill;
    ops.push_back(op);
  endtask

  task automatic add_settle();
    op_t op;
    op.kind  = OP_SETTLE;
    op.data  = '0;
    op.fin   = 1'b0;
    op.idx   = '0;
    op.wdata = '0;
    op.calm  = calm_fill;
    ops.push_back(op);
  endtask

  task automatic add_packet(input int len);
    for (int i = 0; i < len; i++) begin
      add_word(BYTE_W'($urandom), i == len - 1);
    end
  endtask

  // driver: payload and register writes from the op queue
  always @(posedge clk) begin
    op_t  op;
    logic in_go;
    logic cfg_go;
    if (rst) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
      idle_left    = 0;
    end else begin
      in_go  = in_ch.valid;
      cfg_go = cfg_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        encode_word(in_ch.data_byte, in_ch.last_byte);
        words_sent++;
        in_go = 1'b0;
        if (in_ch.last_byte) begin
          in_gap_pct = 15 * $urandom_range(0, 2);
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_CRC_INIT) begin
          seed_crc = cfg_ch.data;
        end else if (cfg_ch.index == REG_CHANNEL) begin
          seed_chan = cfg_ch.data[CHANNEL_W-1:0];
        end
        reg_writes++;
        cfg_go = 1'b0;
      end
      if (!in_go && !cfg_go) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (ops.size() > 0) begin
          op = ops[0];
          case (op.kind)
            OP_SETTLE: begin
              if (expected_words.size() != 0) begin
                settle_left = SETTLE_CYCLES;
              end else if (settle_left > 0) begin
                settle_left--;
              end else begin
                void'(ops.pop_front());
                settle_left = SETTLE_CYCLES;
              end
            end
            OP_WORD: begin
              quiet = op.calm;
              if (!op.calm && $urandom_range(99) < in_gap_pct) begin
                idle_left = $urandom_range(1, 11) - 1;
              end else begin
                in_go = 1'b1;
                in_ch.data_byte <= op.data;
                in_ch.last_byte <= op.fin;
                void'(ops.pop_front());
              end
            end
            OP_WRITE: begin
              cfg_go = 1'b1;
              cfg_ch.index <= op.idx;
              cfg_ch.data  <= op.wdata;
              void'(ops.pop_front());
            end
            default: void'(ops.pop_front());
          endcase
        end
      end
      in_ch.valid  <= in_go;
      cfg_ch.valid <= cfg_go;
    end
  end

  // monitor: compare each accepted output word with the oldest expectation
  always @(posedge clk) begin
    enc_word_t want;
    logic      rdy;
    if (rst) begin
      out_ch.ready <= 1'b0;
      stall_left   = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          note_error($sformatf("unexpected word out_byte=%02h last_out=%0b",
                               out_ch.out_byte, out_ch.last_out));
        end else begin
          want = expected_words.pop_front();
          if (out_ch.out_byte !== want.val || out_ch.last_out !== want.fin) begin
            note_error($sformatf("word %0d: expected %02h/%0b, got %02h/%0b",
                                 words_seen, want.val, want.fin,
                                 out_ch.out_byte, out_ch.last_out));
          end
        end
        if (out_ch.last_out === 1'b1) begin
          packets_seen++;
          out_stall_pct = 15 * $urandom_range(0, 2);
        end
      end
      if (quiet) begin
        rdy = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if ($urandom_range(99) < out_stall_pct) begin
        stall_left = $urandom_range(1, 11) - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ch.ready <= rdy;
    end
  end

  initial begin
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_CRC_INIT;
    cfg_ch.data     = '0;
    out_ch.ready    = 1'b0;

    // directed: defaults, single-byte packet, byte extremes
    add_word(8'h00, 1'b1);
    add_word(8'hFF, 1'b0);
    add_word(8'h80, 1'b0);
    add_word(8'h01, 1'b0);
    add_word(8'h7F, 1'b1);
    add_settle();
    add_write(REG_CRC_INIT, 24'h000000);
    add_write(REG_CHANNEL, 24'd0);
    add_word(8'hAA, 1'b0);
    add_word(8'h55, 1'b1);
    add_settle();
    add_write(REG_CRC_INIT, 24'hFFFFFF);
    add_write(REG_CHANNEL, 24'd39);
    add_word(8'hFF, 1'b1);
    add_word(8'h00, 1'b1);
    add_settle();
    // channel above 39, then a write in the middle of a packet
    add_write(REG_CHANNEL, 24'd63);
    add_word(8'h3C, 1'b0);
    add_settle();
    add_write(REG_CRC_INIT, 24'h123456);
    add_write(REG_CHANNEL, 24'd5);
    add_word(8'hC3, 1'b1);
    add_word(8'h5A, 1'b1);
    add_settle();
    add_write(REG_CRC_INIT, CRC_SEED);
    add_write(REG_CHANNEL, 24'(CHANNEL_RESET));

    // random packets, register changes between phases
    while (planned < ITEM_TARGET) begin
      int len;
      calm_fill = (planned >= CALM_FROM);
      case ($urandom_range(0, 9))
        0, 1: begin
          add_settle();
          add_write(REG_CRC_INIT, ($urandom_range(0, 3) == 0) ?
                    (($urandom_range(0, 1) == 0) ? 24'h000000 : 24'hFFFFFF) :
                    CRC_W'($urandom));
          add_write(REG_CHANNEL, ($urandom_range(0, 4) == 0) ?
                    24'($urandom_range(40, 63)) : 24'($urandom_range(0, 39)));
        end
        2: add_settle();
        default: ;
      endcase
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      if (len > 2 && !calm_fill && $urandom_range(0, 9) == 0) begin
        // write lands mid-packet and only applies from the next packet on
        for (int i = 0; i < len / 2; i++) begin
          add_word(BYTE_W'($urandom), 1'b0);
        end
        add_settle();
        add_write(REG_CHANNEL, 24'($urandom_range(0, 63)));
        add_write(REG_CRC_INIT, CRC_W'($urandom));
        add_packet(len - len / 2);
      end else begin
        add_packet(len);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (ops.size() != 0 || in_ch.valid || cfg_ch.valid) begin
      @(posedge clk);
    end
    while (expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    $display("Sent %0d payload words in %0d packets, checked %0d output words,",
             words_sent, packets_seen, words_seen);
    $display("with %0d register writes across CRC seeds and channels 0..63.", reg_writes);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
